>>> src/config_syntax_checker_assert.svh
// Assertion helpers shared by the checker RTL.
`ifndef CONFIG_SYNTAX_CHECKER_ASSERT_SVH
`define CONFIG_SYNTAX_CHECKER_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define CSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define CSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/csc_pkg.sv
package csc_pkg;

    localparam int MAX_DEPTH   = 15;
    localparam logic [3:0] DEPTH_LIMIT = 4'((MAX_DEPTH < 15) ? MAX_DEPTH : 15);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_OPEN   = 8'h7B;  // {
    localparam logic [7:0] CH_CLOSE  = 8'h7D;  // }
    localparam logic [7:0] CH_HASH   = 8'h23;  // #
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        TK_WORD    = 3'd0,
        TK_OPEN    = 3'd1,
        TK_CLOSE   = 3'd2,
        TK_SEMI    = 3'd3,
        TK_COMMENT = 3'd4,
        TK_END     = 3'd5,
        TK_LEXERR  = 3'd6,
        TK_START   = 3'd7
    } tok_kind_t;

    typedef enum logic [2:0] {
        M_WS      = 3'd0,
        M_WORD    = 3'd1,
        M_SQ      = 3'd2,
        M_DQ      = 3'd3,
        M_COMMENT = 3'd4,
        M_PEND    = 3'd5
    } lex_mode_t;

    typedef enum logic [1:0] {
        V_PARSING  = 2'd0,
        V_ACCEPTED = 2'd1,
        V_REJECTED = 2'd2
    } verdict_t;

    typedef struct packed {
        lex_mode_t  mode;
        logic [7:0] prev_char;
        tok_kind_t  prev_tok;
        logic [3:0] depth;
        logic       rejected;
    } csc_state_t;

    localparam csc_state_t STATE_RESET = '{
        mode: M_WS, prev_char: 8'h00, prev_tok: TK_START, depth: 4'd0, rejected: 1'b0
    };

    typedef struct packed {
        logic       last;
        verdict_t   verdict;
        logic [3:0] depth;
        tok_kind_t  kind;
    } csc_res_t;

    // Up to two results per input beat, first one in r0.
    typedef struct packed {
        logic     v0;
        logic     v1;
        csc_res_t r0;
        csc_res_t r1;
    } csc_out_t;

    typedef struct packed {
        csc_state_t st;
        logic       emit;
        csc_res_t   res;
    } csc_step_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic csc_res_t make_res(tok_kind_t k, logic [3:0] d, verdict_t v);
        csc_res_t r;
        r.last    = 1'b0;
        r.verdict = v;
        r.depth   = d;
        r.kind    = k;
        return r;
    endfunction

    function automatic csc_out_t push_res(csc_out_t o, csc_res_t r, logic en);
        csc_out_t p;
        p = o;
        if (en) begin
            if (!o.v0) begin
                p.v0 = 1'b1;
                p.r0 = r;
            end else begin
                p.v1 = 1'b1;
                p.r1 = r;
            end
        end
        return p;
    endfunction

    // Check a token against the previous one and apply it to the depth.
    function automatic csc_step_t take_token(csc_state_t st, tok_kind_t k);
        csc_step_t t;
        logic      ok;
        t.st   = st;
        t.emit = 1'b0;
        t.res  = make_res(k, st.depth, V_PARSING);
        ok     = 1'b1;
        if (!st.rejected) begin
            if (k == TK_COMMENT) begin
                t.emit = 1'b1;
            end else begin
                case (k)
                    TK_SEMI:  ok = (st.prev_tok == TK_WORD);
                    TK_OPEN:  ok = (st.prev_tok == TK_WORD) && (st.depth < DEPTH_LIMIT);
                    TK_CLOSE: ok = ((st.prev_tok == TK_SEMI) || (st.prev_tok == TK_OPEN) ||
                                    (st.prev_tok == TK_CLOSE)) && (st.depth != 4'd0);
                    default:  ok = 1'b1;
                endcase
                t.emit = 1'b1;
                if (!ok) begin
                    t.st.rejected = 1'b1;
                    t.res = make_res(k, st.depth, V_REJECTED);
                end else begin
                    if (k == TK_OPEN) begin
                        t.st.depth = st.depth + 4'd1;
                    end else if (k == TK_CLOSE) begin
                        t.st.depth = st.depth - 4'd1;
                    end
                    t.st.prev_tok = k;
                    t.res = make_res(k, t.st.depth, V_PARSING);
                end
            end
        end
        return t;
    endfunction

    // Scan a byte from whitespace mode.
    function automatic csc_step_t scan_fresh(csc_state_t st, logic [7:0] c);
        csc_step_t t;
        t.st   = st;
        t.emit = 1'b0;
        t.res  = make_res(TK_WORD, st.depth, V_PARSING);
        case (c)
            CH_OPEN:  t = take_token(st, TK_OPEN);
            CH_CLOSE: t = take_token(st, TK_CLOSE);
            CH_SEMI:  t = take_token(st, TK_SEMI);
            CH_HASH:  t.st.mode = M_COMMENT;
            CH_DQUOTE: begin
                t.st.mode      = M_DQ;
                t.st.prev_char = c;
            end
            CH_SQUOTE: begin
                t.st.mode      = M_SQ;
                t.st.prev_char = c;
            end
            default: begin
                if (!is_space(c)) begin
                    t.st.mode = M_WORD;
                end
            end
        endcase
        return t;
    endfunction

endpackage

>>> src/csc_scan.sv
`include "config_syntax_checker_assert.svh"

module csc_scan
    import csc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       item_end,
    input  logic [7:0] text_byte,
    output csc_out_t   result
);

    csc_state_t state_reg;
    csc_state_t state_next;

    always_comb begin
        csc_state_t st;
        csc_step_t  t;
        csc_out_t   o;
        logic [7:0] q;
        st = state_reg;
        o  = '0;
        t  = '0;
        q  = CH_DQUOTE;
        if (step) begin
            if (item_end) begin
                if (!st.rejected &&
                    (st.mode == M_SQ || st.mode == M_DQ || st.mode == M_PEND)) begin
                    st.rejected = 1'b1;
                    o = push_res(o, make_res(TK_LEXERR, st.depth, V_REJECTED), 1'b1);
                end else begin
                    if (st.mode == M_WORD) begin
                        t  = take_token(st, TK_WORD);
                        st = t.st;
                        o  = push_res(o, t.res, t.emit);
                    end
                    if (st.rejected) begin
                        o = push_res(o, make_res(TK_END, st.depth, V_REJECTED), 1'b1);
                    end else if ((st.prev_tok == TK_SEMI || st.prev_tok == TK_CLOSE) &&
                                 st.depth == 4'd0) begin
                        o = push_res(o, make_res(TK_END, st.depth, V_ACCEPTED), 1'b1);
                    end else begin
                        o = push_res(o, make_res(TK_END, st.depth, V_REJECTED), 1'b1);
                    end
                end
                st = STATE_RESET;
            end else if (!st.rejected) begin
                case (st.mode)
                    M_WORD: begin
                        if (is_space(text_byte) || text_byte == CH_SEMI ||
                            text_byte == CH_OPEN || text_byte == CH_CLOSE) begin
                            st.mode = M_WS;
                            t  = take_token(st, TK_WORD);
                            st = t.st;
                            o  = push_res(o, t.res, t.emit);
                            if (!st.rejected) begin
                                t  = scan_fresh(st, text_byte);
                                st = t.st;
                                o  = push_res(o, t.res, t.emit);
                            end
                        end
                    end
                    M_SQ, M_DQ: begin
                        q = (st.mode == M_SQ) ? CH_SQUOTE : CH_DQUOTE;
                        if (text_byte == q && st.prev_char != CH_BSLASH) begin
                            st.mode = M_PEND;
                        end
                        st.prev_char = text_byte;
                    end
                    M_PEND: begin
                        st.mode = M_WS;
                        if (is_space(text_byte) || text_byte == CH_SEMI) begin
                            t  = take_token(st, TK_WORD);
                            st = t.st;
                            o  = push_res(o, t.res, t.emit);
                            if (!st.rejected) begin
                                t  = scan_fresh(st, text_byte);
                                st = t.st;
                                o  = push_res(o, t.res, t.emit);
                            end
                        end else begin
                            st.rejected = 1'b1;
                            o = push_res(o, make_res(TK_LEXERR, st.depth, V_REJECTED), 1'b1);
                        end
                    end
                    M_COMMENT: begin
                        if (text_byte == CH_LF || text_byte == CH_CR) begin
                            st.mode = M_WS;
                            t  = take_token(st, TK_COMMENT);
                            st = t.st;
                            o  = push_res(o, t.res, t.emit);
                        end
                    end
                    default: begin
                        st.mode = M_WS;
                        t  = scan_fresh(st, text_byte);
                        st = t.st;
                        o  = push_res(o, t.res, t.emit);
                    end
                endcase
            end
            // mark the final result of this beat
            if (o.v1) begin
                o.r1.last = 1'b1;
            end else if (o.v0) begin
                o.r0.last = 1'b1;
            end
        end
        state_next = st;
        result     = o;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    `CSC_ASSERT_NXT(a_end_restarts, step && item_end, state_reg.mode == M_WS && state_reg.depth == 4'd0 && !state_reg.rejected, "end marker did not restart the scanner")
    `CSC_ASSERT_IMP(a_quiet_after_reject, step && !item_end && state_reg.rejected, !result.v0, "result produced after rejection")
    `CSC_ASSERT_IMP(a_second_after_first, result.v1, result.v0 && result.r1.last && !result.r0.last, "second result without proper first")

endmodule

>>> src/config_syntax_checker.sv
// Results are registered in the result queue before they are offered on m_.
// One input beat per cycle while s_tready is high; the scanner has no internal stall.
// A byte that closes a word can yield two result beats, drained one per cycle from a
// four-entry result queue while m_tready is high; s_tready drops while fewer than two
// queue slots are free. Reset (aresetn low, synchronous): scanner back to whitespace,
// depth zero, start of file, no rejection; result queue emptied.
`include "config_syntax_checker_assert.svh"

module config_syntax_checker
    import csc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] kind (1 = end of input)

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] token_kind, [6:3] nesting_depth, [8:7] verdict
    output logic        m_tlast    // last_of_run
);

    logic     s_fire;
    logic     m_fire;
    csc_out_t scan_out;

    // Result queue: small register file with its own read and write pointers.
    csc_res_t              queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   push_cnt;
    csc_res_t              head;

    // Accept a beat only while two slots are free, so a two-result beat always fits.
    assign s_tready = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;

    // Scanner: holds the lexer state and produces zero, one or two results per beat.
    csc_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s_fire),
        .item_end  (s_tuser[0]),
        .text_byte (s_tdata),
        .result    (scan_out)
    );

    assign push_cnt = QUEUE_CW'(scan_out.v0) + QUEUE_CW'(scan_out.v1);

    // Advance pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(m_fire);
            count_reg  <= count_reg + push_cnt - QUEUE_CW'(m_fire);
        end
    end

    // Payload storage: first result at the write pointer, second right after it.
    always_ff @(posedge aclk) begin
        if (scan_out.v0) begin
            queue_reg[wr_ptr_reg] <= scan_out.r0;
        end
        if (scan_out.v1) begin
            queue_reg[wr_ptr_reg + QUEUE_AW'(1)] <= scan_out.r1;
        end
    end

    // Present the head entry.
    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = {7'b0, head.verdict, head.depth, head.kind};
    assign m_tlast = head.last;

    `CSC_ASSERT_IMP(a_queue_bound, 1'b1, count_reg <= QUEUE_CW'(QUEUE_DEPTH), "result queue overflow")
    `CSC_ASSERT_IMP(a_room_on_accept, s_fire, count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2), "beat accepted without room for two results")
    `CSC_ASSERT_NXT(a_drain, m_fire && !scan_out.v0, count_reg == $past(count_reg) - QUEUE_CW'(1), "queue occupancy did not drop on pop")

endmodule
